### src/des_rf_pkg.sv
// Package: DES f-function bit selection tables and S-box contents.
`timescale 1ns / 1ps

package des_rf_pkg;

  localparam int unsigned HALF_W = 32;
  localparam int unsigned KEY_W  = 48;
  localparam int unsigned NBOX   = 8;

  typedef logic [HALF_W-1:0] half_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [4:0]        bitpos_t;
  typedef logic [3:0]        nib_t;

  // E expansion: source bit (LSB = 0) for each output bit, listed from output MSB down
  localparam bitpos_t E_SRC [0:KEY_W-1] = '{
    5'd0,  5'd31, 5'd30, 5'd29, 5'd28, 5'd27, 5'd28, 5'd27, 5'd26, 5'd25, 5'd24, 5'd23,
    5'd24, 5'd23, 5'd22, 5'd21, 5'd20, 5'd19, 5'd20, 5'd19, 5'd18, 5'd17, 5'd16, 5'd15,
    5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd11, 5'd12, 5'd11, 5'd10, 5'd9,  5'd8,  5'd7,
    5'd8,  5'd7,  5'd6,  5'd5,  5'd4,  5'd3,  5'd4,  5'd3,  5'd2,  5'd1,  5'd0,  5'd31
  };

  // P permutation: source bit (LSB = 0) for each output bit, from output MSB down
  localparam bitpos_t P_SRC [0:HALF_W-1] = '{
    5'd16, 5'd25, 5'd12, 5'd11, 5'd3,  5'd20, 5'd4,  5'd15,
    5'd31, 5'd17, 5'd9,  5'd6,  5'd27, 5'd14, 5'd1,  5'd22,
    5'd30, 5'd24, 5'd8,  5'd18, 5'd0,  5'd5,  5'd29, 5'd23,
    5'd13, 5'd19, 5'd2,  5'd26, 5'd10, 5'd21, 5'd28, 5'd7
  };

  localparam nib_t SBOX_TAB [0:NBOX-1][0:3][0:15] = '{
    '{'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7},
      '{4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8},
      '{4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0},
      '{4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13}},
    '{'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10},
      '{4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5},
      '{4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15},
      '{4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9}},
    '{'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8},
      '{4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1},
      '{4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7},
      '{4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12}},
    '{'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15},
      '{4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9},
      '{4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4},
      '{4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14}},
    '{'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9},
      '{4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6},
      '{4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14},
      '{4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3}},
    '{'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11},
      '{4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8},
      '{4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6},
      '{4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13}},
    '{'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1},
      '{4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6},
      '{4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2},
      '{4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12}},
    '{'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7},
      '{4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2},
      '{4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8},
      '{4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}}
  };

endpackage

### src/des_round_function.sv
// Top level: three-stage pipelined DES f-function (E/XOR, S-boxes, P).
//
//   channel | ports                                   | dir
//   --------+-----------------------------------------+-----
//   in      | in_valid, in_ready, in_right_half[31:0], | in
//           | in_subkey[47:0]                          |
//   out     | out_valid, out_ready, out_f_value[31:0]  | out
//
// The accepting edge loads stage 1; the request moves on through stage 2 to stage 3,
// whose register drives out_valid. One request per cycle sustained while out_ready is high.
// Stage 1 holds E(R) ^ K, stage 2 the S-box nibbles, stage 3 the P output register.
// Each stage advances when the stage after it is empty or moving, so a stall on out
// backs up stage by stage and the pipeline holds up to three requests.
// Synchronous active-low reset clears the valid bits only.
`timescale 1ns / 1ps

module des_round_function (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  des_rf_pkg::half_t   in_right_half,
  input  des_rf_pkg::key_t    in_subkey,
  output logic                out_valid,
  input  logic                out_ready,
  output des_rf_pkg::half_t   out_f_value
);
  import des_rf_pkg::*;

  logic  v1_r, v2_r, v3_r;
  logic  v1_nxt, v2_nxt, v3_nxt;
  key_t  x1_r, x1_nxt;
  half_t s2_r, s2_nxt;
  half_t f3_r, f3_nxt;
  logic  rdy1, rdy2, rdy3;

  assign rdy3 = !v3_r || out_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ready = rdy1;

  // stage 1: expansion and key mix
  always_comb begin
    for (int i = 0; i < int'(KEY_W); i++) begin
      x1_nxt[KEY_W-1-i] = in_right_half[E_SRC[i]] ^ in_subkey[KEY_W-1-i];
    end
  end

  // stage 2: S-boxes, row = outer bits, column = middle four
  always_comb begin
    for (int k = 0; k < int'(NBOX); k++) begin
      s2_nxt[HALF_W-1-4*k -: 4] =
        SBOX_TAB[k][{x1_r[KEY_W-1-6*k], x1_r[KEY_W-6-6*k]}][x1_r[KEY_W-2-6*k -: 4]];
    end
  end

  // stage 3: P permutation
  always_comb begin
    for (int i = 0; i < int'(HALF_W); i++) begin
      f3_nxt[HALF_W-1-i] = s2_r[P_SRC[i]];
    end
  end

  always_comb begin
    v1_nxt = rdy1 ? in_valid : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) x1_r <= x1_nxt;
    if (rdy2) s2_r <= s2_nxt;
    if (rdy3) f3_r <= f3_nxt;
  end

  assign out_valid   = v3_r;
  assign out_f_value = f3_r;

  // a stalled middle stage keeps its request
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !rdy3 |=> v2_r && $stable(s2_r))
    else $error("stage 2 lost or changed a stalled request");

  // an accepted request lands in stage 1
  a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted request missing from stage 1");

  // a new result only appears after stage 2 held one
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(v2_r))
    else $error("result appeared without a stage 2 request");

  // output draining means the whole pipe can take a request
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while output drains");

endmodule
